// ----- hw/rtl/bmn_pkg.sv -----
package bmn_pkg;

    localparam int NODES      = 16;
    localparam int IDX_W      = 4;
    localparam int WT_W       = 16;
    localparam int MSG_W      = 24;
    localparam int B_W        = 4;
    localparam int CNT_W      = 8;
    localparam int WA_W       = 2 * IDX_W;
    localparam int MA_W       = 1 + 2 * IDX_W;
    localparam int WT_DEPTH   = NODES * NODES;
    localparam int MSG_DEPTH  = 2 * NODES * NODES;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_UPDATE  = 2'd1,
        OP_CHECK   = 2'd2,
        OP_RESTART = 2'd3
    } t_op;

    localparam logic KIND_BELIEF = 1'b0;
    localparam logic KIND_CHECK  = 1'b1;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_RD,
        S_CMP,
        S_MIN,
        S_BTH,
        S_WRD,
        S_WR,
        S_BEL,
        S_CHK,
        S_CHKW,
        S_CHKO
    } t_state;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [MSG_W-1:0] t_msg;

    typedef struct packed {
        logic            clr;
        logic            clr_w;
        logic [MA_W-1:0] clr_addr;
        logic            ld_w;
        logic            latch;
        logic            upd_start;
        logic            rd_en;
        t_idx            rd_idx;
        logic            cmp;
        logic            mnx;
        logic            bth;
        logic            wr;
        t_idx            idx;
        logic            bel;
        t_idx            slot;
        t_idx            bcnt;
        logic            last;
        logic            chk_clr;
        logic            chk_rd;
        t_idx            chk_i;
        t_idx            chk_j;
        logic            chk_emit;
        logic [B_W-1:0]  b;
    } t_cmd;

    typedef struct packed {
        t_idx minind;
    } t_stat;

    typedef struct packed {
        t_idx idx;
        t_msg val;
    } t_min;

    // saturate a 25-bit signed value to 24 bits
    function automatic t_msg sat24(input logic [MSG_W:0] v);
        t_msg r;
        if (v[MSG_W] != v[MSG_W-1]) begin
            r = v[MSG_W] ? {1'b1, {(MSG_W-1){1'b0}}} : {1'b0, {(MSG_W-1){1'b1}}};
        end else begin
            r = v[MSG_W-1:0];
        end
        return r;
    endfunction

    // lowest index holding the minimum among masked slots; ties go low
    function automatic t_min min_first(input logic [NODES-1:0][MSG_W-1:0] v,
                                       input logic [NODES-1:0] m);
        logic [NODES-1:0][MSG_W-1:0] tv;
        logic [NODES-1:0][IDX_W-1:0] ti;
        logic [NODES-1:0]            tm;
        t_min                        r;
        int                          lvl;
        int                          k;
        int                          o;
        tv = v;
        tm = m;
        for (k = 0; k < NODES; k++) begin
            ti[k] = IDX_W'(k);
        end
        for (lvl = 0; lvl < IDX_W; lvl++) begin
            for (k = 0; k < NODES; k = k + (2 << lvl)) begin
                o = k + (1 << lvl);
                if (tm[o] && (!tm[k] || ($signed(tv[o]) < $signed(tv[k])))) begin
                    tv[k] = tv[o];
                    ti[k] = ti[o];
                end
                tm[k] = tm[k] | tm[o];
            end
        end
        r.idx = ti[0];
        r.val = tv[0];
        return r;
    endfunction

endpackage

// ----- hw/rtl/bmn_ram.sv -----
module bmn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/bmn_ctrl.sv -----
module bmn_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [1:0]                    i_opcode,
    input  logic [bmn_pkg::IDX_W-1:0]     i_node_index,
    input  logic [bmn_pkg::IDX_W-1:0]     i_partner_index,
    input  logic                          i_cfg_valid,
    input  logic [bmn_pkg::B_W-1:0]       i_cfg_b_count,
    output logic                          o_cfg_ready,
    output logic                          o_busy,
    output bmn_pkg::t_cmd                 o_cmd,
    input  bmn_pkg::t_stat                i_stat
);
    import bmn_pkg::*;

    t_state            r_state, n_state;
    t_idx              r_i, n_i;
    t_idx              r_s, n_s;
    t_idx              r_bc, n_bc;
    t_idx              r_ci, n_ci;
    t_idx              r_cj, n_cj;
    logic [MA_W-1:0]   r_ccnt, n_ccnt;
    logic              r_clr_w, n_clr_w;
    logic [B_W-1:0]    r_b_count;
    logic [B_W-1:0]    eff_b;
    logic [B_W-1:0]    b_m1;
    t_op               op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_i       <= '0;
            r_s       <= '0;
            r_bc      <= '0;
            r_ci      <= '0;
            r_cj      <= '0;
            r_ccnt    <= '0;
            r_clr_w   <= 1'b1;
            r_b_count <= B_W'(1);
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_s     <= n_s;
            r_bc    <= n_bc;
            r_ci    <= n_ci;
            r_cj    <= n_cj;
            r_ccnt  <= n_ccnt;
            r_clr_w <= n_clr_w;
            if (i_cfg_valid) begin
                r_b_count <= i_cfg_b_count;
            end
        end
    end

    always_comb begin
        if (r_b_count == '0) begin
            eff_b = B_W'(1);
        end else if (int'(r_b_count) > NODES - 1) begin
            eff_b = B_W'(NODES - 1);
        end else begin
            eff_b = r_b_count;
        end
        b_m1 = eff_b - B_W'(1);
    end

    assign o_cfg_ready = 1'b1;
    assign o_busy      = (r_state != S_IDLE);
    assign op          = t_op'(i_opcode);

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_s     = r_s;
        n_bc    = r_bc;
        n_ci    = r_ci;
        n_cj    = r_cj;
        n_ccnt  = r_ccnt;
        n_clr_w = r_clr_w;
        o_cmd          = '0;
        o_cmd.b        = eff_b;
        o_cmd.clr_addr = r_ccnt;
        o_cmd.clr_w    = r_clr_w;
        o_cmd.idx      = r_i;
        o_cmd.slot     = r_s;
        o_cmd.bcnt     = r_bc;
        o_cmd.chk_i    = r_ci;
        o_cmd.chk_j    = r_cj;
        case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (r_ccnt == MA_W'(MSG_DEPTH - 1)) begin
                    n_ccnt  = '0;
                    n_clr_w = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    n_ccnt = r_ccnt + MA_W'(1);
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    case (op)
                        OP_LOAD: begin
                            o_cmd.ld_w = (int'(i_node_index) < NODES) &&
                                         (int'(i_partner_index) < NODES);
                        end
                        OP_UPDATE: begin
                            if (int'(i_node_index) < NODES) begin
                                o_cmd.latch     = 1'b1;
                                o_cmd.upd_start = 1'b1;
                                n_state         = S_RD;
                            end
                        end
                        OP_CHECK: begin
                            o_cmd.chk_clr = 1'b1;
                            n_ci          = '0;
                            n_cj          = '0;
                            n_state       = S_CHK;
                        end
                        OP_RESTART: begin
                            n_ccnt  = '0;
                            n_clr_w = 1'b0;
                            n_state = S_CLR;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_idx = '0;
                n_i          = '0;
                n_state      = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = S_MIN;
            end
            S_MIN: begin
                o_cmd.mnx = 1'b1;
                if (r_i == IDX_W'(NODES - 1)) begin
                    n_state = S_BTH;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_idx = r_i + IDX_W'(1);
                    n_i          = r_i + IDX_W'(1);
                    n_state      = S_CMP;
                end
            end
            S_BTH: begin
                o_cmd.bth = 1'b1;
                n_state   = S_WRD;
            end
            S_WRD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_idx = '0;
                n_i          = '0;
                n_state      = S_WR;
            end
            S_WR: begin
                o_cmd.wr = 1'b1;
                if (r_i == IDX_W'(NODES - 1)) begin
                    n_s     = '0;
                    n_bc    = '0;
                    n_state = S_BEL;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_idx = r_i + IDX_W'(1);
                    n_i          = r_i + IDX_W'(1);
                end
            end
            S_BEL: begin
                // the weakest of the b+1 slots is skipped
                if (r_s != i_stat.minind) begin
                    o_cmd.bel  = 1'b1;
                    o_cmd.last = (r_bc == b_m1);
                    n_bc       = r_bc + IDX_W'(1);
                end
                if (r_s == eff_b) begin
                    n_state = S_IDLE;
                end else begin
                    n_s = r_s + IDX_W'(1);
                end
            end
            S_CHK: begin
                o_cmd.chk_rd = 1'b1;
                if (r_cj == b_m1) begin
                    n_cj = '0;
                    if (r_ci == IDX_W'(NODES - 1)) begin
                        n_state = S_CHKW;
                    end else begin
                        n_ci = r_ci + IDX_W'(1);
                    end
                end else begin
                    n_cj = r_cj + IDX_W'(1);
                end
            end
            S_CHKW: begin
                n_state = S_CHKO;
            end
            S_CHKO: begin
                o_cmd.chk_emit = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/bmn_dp.sv -----
module bmn_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  bmn_pkg::t_cmd             i_cmd,
    output bmn_pkg::t_stat            o_stat,
    input  logic                      i_node_side,
    input  logic [bmn_pkg::IDX_W-1:0] i_node_index,
    input  logic [bmn_pkg::IDX_W-1:0] i_partner_index,
    input  logic [bmn_pkg::WT_W-1:0]  i_log_weight,
    output logic                      o_strobe,
    output logic                      o_result_kind,
    output logic [bmn_pkg::IDX_W-1:0] o_belief_index,
    output logic                      o_matching_ok,
    output logic                      o_last
);
    import bmn_pkg::*;

    logic                        r_side;
    t_idx                        r_id;
    logic [NODES-1:0][MSG_W-1:0] r_val;
    t_idx                        r_top [NODES];
    t_idx                        r_minind;
    t_msg                        r_minval;
    t_msg                        r_bthval;
    logic [CNT_W-1:0]            r_counts [NODES];
    logic                        r_chk_v;
    logic                        r_strobe;
    logic                        r_kind;
    t_idx                        r_bidx;
    logic                        r_ok;
    logic                        r_last;

    logic                        w_we;
    logic [WA_W-1:0]             w_waddr;
    logic [WA_W-1:0]             w_raddr;
    logic [WT_W-1:0]             w_wdata;
    logic [WT_W-1:0]             w_rd;
    logic                        m_we;
    logic [MA_W-1:0]             m_waddr;
    t_msg                        m_wdata;
    t_msg                        m_rd;
    logic                        b_we;
    logic [MA_W-1:0]             b_waddr;
    t_idx                        b_wdata;
    t_idx                        b_rd;

    t_msg                        wv;
    t_msg                        d;
    t_idx                        lim;
    logic                        fill;
    logic                        repl;
    logic [NODES-1:0]            mask_min;
    logic [NODES-1:0]            mask_bth;
    t_min                        res_min;
    t_min                        res_bth;
    logic                        ok;

    assign w_we    = (i_cmd.clr && i_cmd.clr_w) || i_cmd.ld_w;
    assign w_waddr = i_cmd.clr ? i_cmd.clr_addr[WA_W-1:0] : {i_node_index, i_partner_index};
    assign w_wdata = i_cmd.clr ? '0 : i_log_weight;
    assign w_raddr = r_side ? {i_cmd.rd_idx, r_id} : {r_id, i_cmd.rd_idx};

    bmn_ram #(.WIDTH(WT_W), .DEPTH(WT_DEPTH)) u_weights (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    assign m_we    = i_cmd.clr || i_cmd.wr;
    assign m_waddr = i_cmd.clr ? i_cmd.clr_addr : {r_side, r_id, i_cmd.idx};

    bmn_ram #(.WIDTH(MSG_W), .DEPTH(MSG_DEPTH)) u_messages (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr ({~r_side, i_cmd.rd_idx, r_id}),
        .o_rdata (m_rd)
    );

    assign b_we    = i_cmd.clr || i_cmd.bel;
    assign b_waddr = i_cmd.clr ? i_cmd.clr_addr : {r_side, r_id, i_cmd.bcnt};
    assign b_wdata = i_cmd.clr ? i_cmd.clr_addr[IDX_W-1:0] : r_top[i_cmd.slot];

    bmn_ram #(.WIDTH(IDX_W), .DEPTH(MSG_DEPTH)) u_beliefs (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (b_wdata),
        .i_re    (i_cmd.chk_rd),
        .i_raddr ({1'b0, i_cmd.chk_i, i_cmd.chk_j}),
        .o_rdata (b_rd)
    );

    always_comb begin
        wv   = sat24({{(MSG_W + 1 - WT_W){w_rd[WT_W-1]}}, w_rd} + {m_rd[MSG_W-1], m_rd});
        lim  = (i_cmd.idx < i_cmd.b) ? i_cmd.idx : i_cmd.b;
        fill = (i_cmd.idx <= i_cmd.b);
        repl = ($signed(wv) > $signed(r_minval));
        for (int k = 0; k < NODES; k++) begin
            mask_min[k] = (IDX_W'(k) <= lim);
            mask_bth[k] = (IDX_W'(k) <= i_cmd.b) && (IDX_W'(k) != r_minind);
        end
        res_min = min_first(r_val, mask_min);
        res_bth = min_first(r_val, mask_bth);
        d       = ($signed(wv) >= $signed(r_bthval)) ? r_minval : r_bthval;
        m_wdata = i_cmd.clr ? '0 :
                  sat24({{(MSG_W + 1 - WT_W){w_rd[WT_W-1]}}, w_rd} - {d[MSG_W-1], d});
        ok = 1'b1;
        for (int k = 0; k < NODES; k++) begin
            if (r_counts[k] != CNT_W'(i_cmd.b)) begin
                ok = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_side <= i_node_side;
            r_id   <= i_node_index;
        end
        if (i_cmd.cmp) begin
            if (fill) begin
                r_top[i_cmd.idx] <= i_cmd.idx;
                r_val[i_cmd.idx] <= wv;
            end else if (repl) begin
                r_top[r_minind] <= i_cmd.idx;
                r_val[r_minind] <= wv;
            end
        end
        if (i_cmd.upd_start) begin
            r_minind <= '0;
        end else if (i_cmd.mnx) begin
            // keep the current weakest slot if it still holds the minimum
            if (r_val[r_minind] != res_min.val) begin
                r_minind <= res_min.idx;
            end
            r_minval <= res_min.val;
        end
        if (i_cmd.bth) begin
            r_bthval <= res_bth.val;
        end
        if (i_cmd.chk_clr) begin
            for (int k = 0; k < NODES; k++) begin
                r_counts[k] <= '0;
            end
        end else if (r_chk_v) begin
            r_counts[b_rd] <= r_counts[b_rd] + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk_v  <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_chk_v  <= i_cmd.chk_rd;
            r_strobe <= i_cmd.bel || i_cmd.chk_emit;
        end
        r_kind <= i_cmd.chk_emit ? KIND_CHECK : KIND_BELIEF;
        r_bidx <= i_cmd.bel ? r_top[i_cmd.slot] : '0;
        r_ok   <= i_cmd.chk_emit && ok;
        r_last <= i_cmd.chk_emit || i_cmd.last;
    end

    assign o_stat.minind  = r_minind;
    assign o_strobe       = r_strobe;
    assign o_result_kind  = r_kind;
    assign o_belief_index = r_bidx;
    assign o_matching_ok  = r_ok;
    assign o_last         = r_last;

endmodule

// ----- hw/rtl/bp_bmatching_node_update.sv -----
// Channel   | Signals                                          | Handshake
// ----------+--------------------------------------------------+----------------------------
// command   | i_opcode i_node_side i_node_index                | start & !busy
//           | i_partner_index i_log_weight                     |
// result    | o_result_kind o_belief_index o_matching_ok o_last| o_strobe, one cycle
// config    | i_cfg_b_count                                    | i_cfg_valid & o_cfg_ready
//
// Load: busy stays low. Update (busy): per partner a read, then insert and min
// search over the b+1 slots; then a message write per partner and a belief per
// slot, each belief registered onto the result outputs in the following cycle.
// Check (busy): one belief memory read per entry, then a wait state and an emit
// state, whose verdict is registered. Restart and reset: a clearing pass over the
// message and belief memories (reset also clears weights). Results cannot be held.
module bp_bmatching_node_update (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_opcode,
    input  logic                      i_node_side,
    input  logic [bmn_pkg::IDX_W-1:0] i_node_index,
    input  logic [bmn_pkg::IDX_W-1:0] i_partner_index,
    input  logic [bmn_pkg::WT_W-1:0]  i_log_weight,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [bmn_pkg::B_W-1:0]   i_cfg_b_count,
    output logic                      o_strobe,
    output logic                      o_result_kind,
    output logic [bmn_pkg::IDX_W-1:0] o_belief_index,
    output logic                      o_matching_ok,
    output logic                      o_last
);
    import bmn_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    bmn_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_opcode        (i_opcode),
        .i_node_index    (i_node_index),
        .i_partner_index (i_partner_index),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_b_count   (i_cfg_b_count),
        .o_cfg_ready     (o_cfg_ready),
        .o_busy          (busy),
        .o_cmd           (cmd),
        .i_stat          (stat)
    );

    bmn_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_node_side     (i_node_side),
        .i_node_index    (i_node_index),
        .i_partner_index (i_partner_index),
        .i_log_weight    (i_log_weight),
        .o_strobe        (o_strobe),
        .o_result_kind   (o_result_kind),
        .o_belief_index  (o_belief_index),
        .o_matching_ok   (o_matching_ok),
        .o_last          (o_last)
    );

endmodule

// ----- hw/rtl/bmn_chk.sv -----
module bmn_chk (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      start,
    input logic                      busy,
    input logic [1:0]                i_opcode,
    input logic                      o_strobe,
    input logic                      o_result_kind,
    input logic [bmn_pkg::IDX_W-1:0] o_belief_index,
    input logic                      o_matching_ok,
    input logic                      o_last
);
    import bmn_pkg::*;

    // reset always starts the clearing pass
    a_reset_busy: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("not busy after reset");

    a_check_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_opcode == OP_CHECK) |=> busy)
        else $error("check item not started");

    a_verdict_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result_kind == KIND_CHECK) |-> (o_last && o_belief_index == '0))
        else $error("bad check verdict fields");

    a_belief_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result_kind == KIND_BELIEF) |-> !o_matching_ok)
        else $error("matching flag set on belief");

endmodule

bind bp_bmatching_node_update bmn_chk u_bmn_chk (.*);
